// ===== rtl/per_key_online_regression_slope_defines.svh =====
// Assertion macros for the per-key regression slope block.
// Used by the top level only; expects signals named clock and reset in scope.
`ifndef PER_KEY_ONLINE_REGRESSION_SLOPE_DEFINES_SVH
`define PER_KEY_ONLINE_REGRESSION_SLOPE_DEFINES_SVH

// Same-cycle implication, disabled during reset.
`define PKORS_ASSERT_IMPL(lbl, ante, cons) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error("pkors assertion failed");

// Next-cycle implication, disabled during reset.
`define PKORS_ASSERT_NEXT(lbl, ante, cons) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error("pkors assertion failed");

`endif

// ===== rtl/pkors_pkg.sv =====
// Shared types and codes for the per-key regression slope block.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none

package pkors_pkg;

   // Event kinds
   localparam logic KIND_SAMPLE = 1'b0;
   localparam logic KIND_QUERY  = 1'b1;

   // Result status codes
   localparam logic [1:0] STAT_OK         = 2'd0;
   localparam logic [1:0] STAT_NO_SAMPLES = 2'd1;
   localparam logic [1:0] STAT_ZERO_VAR   = 2'd2;
   localparam logic [1:0] STAT_SATURATED  = 2'd3;

   typedef struct packed {
      logic               kind;
      logic [9:0]         key;
      logic               key_present;
      logic signed [15:0] x_value;
      logic               x_missing;
      logic signed [15:0] t_value;
      logic [15:0]        result_slot;
   } req_type;

   typedef struct packed {
      logic signed [31:0] slope;
      logic [1:0]         status;
      logic [15:0]        answer_slot;
   } rsp_type;

   // Table write controls
   typedef struct packed {
      logic sums_we;
      logic seen_we;
      logic seen_data;
   } tbl_ctl_type;

endpackage

`default_nettype wire

// ===== rtl/pkors_alu.sv =====
// Shared add/subtract unit with unsigned no-borrow flag.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none

module pkors_alu #(
   parameter int WIDTH = 96
) (
   input  wire logic [WIDTH-1:0] a,
   input  wire logic [WIDTH-1:0] b,
   input  wire logic             sub,
   output logic      [WIDTH-1:0] sum,
   output logic                  carry
);

   logic [WIDTH:0] full;

   // a + b, or a - b as a + ~b + 1; carry set on subtract means a >= b
   assign full  = {1'b0, a} + {1'b0, (sub ? ~b : b)} + {{WIDTH{1'b0}}, sub};
   assign sum   = full[WIDTH-1:0];
   assign carry = full[WIDTH];

endmodule

`default_nettype wire

// ===== rtl/pkors_table.sv =====
// Per-key state memories: seen flags, count and running sums.
// Depends on pkors_pkg for the write control struct.
`timescale 1ns / 1ps
`default_nettype none

module pkors_table #(
   parameter int KEY_COUNT  = 1024,
   parameter int COUNT_BITS = 16,
   localparam int IW = $clog2(KEY_COUNT),
   localparam int W  = 16 + COUNT_BITS,
   localparam int P  = 32 + COUNT_BITS
) (
   input  wire logic                  clock,
   input  wire pkors_pkg::tbl_ctl_type ctl,
   input  wire logic [IW-1:0]         wr_addr,
   input  wire logic [COUNT_BITS-1:0] wr_cnt,
   input  wire logic [W-1:0]          wr_sx,
   input  wire logic [W-1:0]          wr_st,
   input  wire logic [P-1:0]          wr_sxt,
   input  wire logic [P-1:0]          wr_sxx,
   input  wire logic [IW-1:0]         rd_addr,
   output logic                       rd_seen,
   output logic [COUNT_BITS-1:0]      rd_cnt,
   output logic [W-1:0]               rd_sx,
   output logic [W-1:0]               rd_st,
   output logic [P-1:0]               rd_sxt,
   output logic [P-1:0]               rd_sxx
);

   logic                  seen_mem [KEY_COUNT];
   logic [COUNT_BITS-1:0] cnt_mem  [KEY_COUNT];
   logic [W-1:0]          sx_mem   [KEY_COUNT];
   logic [W-1:0]          st_mem   [KEY_COUNT];
   logic [P-1:0]          sxt_mem  [KEY_COUNT];
   logic [P-1:0]          sxx_mem  [KEY_COUNT];

   // Seen flags, cleared by the sweep after reset
   always_ff @(posedge clock) begin
      if (ctl.seen_we) begin
         seen_mem[wr_addr] <= ctl.seen_data;
      end
      rd_seen <= seen_mem[rd_addr];
   end

   // Count and sums
   always_ff @(posedge clock) begin
      if (ctl.sums_we) begin
         cnt_mem[wr_addr] <= wr_cnt;
         sx_mem[wr_addr]  <= wr_sx;
         st_mem[wr_addr]  <= wr_st;
         sxt_mem[wr_addr] <= wr_sxt;
         sxx_mem[wr_addr] <= wr_sxx;
      end
      rd_cnt <= cnt_mem[rd_addr];
      rd_sx  <= sx_mem[rd_addr];
      rd_st  <= st_mem[rd_addr];
      rd_sxt <= sxt_mem[rd_addr];
      rd_sxx <= sxx_mem[rd_addr];
   end

endmodule

`default_nettype wire

// ===== rtl/per_key_online_regression_slope.sv =====
// Per-key online least-squares slope: top level with sequencer and datapath.
// Depends on pkors_pkg, pkors_alu, pkors_table and the defines header.
`timescale 1ns / 1ps
`default_nettype none
`include "per_key_online_regression_slope_defines.svh"

// After reset the block sweeps its seen-flag memory, one key per cycle, and
// holds req_ready low until every key is cleared. A sample event then takes a
// table read, then a read-modify-write. A query forms the four products of the
// numerator and denominator by shift-and-add over the multiplier bits, then
// runs a 33-step restoring division, all on one shared add/subtract unit. A
// query for an absent or unseen key skips the products and the division. Only
// one event is in work at a time; the result register lets the next event
// enter while a result waits for rsp_ready.
module per_key_online_regression_slope #(
   parameter int KEY_COUNT  = 1024,
   parameter int COUNT_BITS = 16
) (
   input  wire logic               clock,
   input  wire logic               reset,
   input  wire logic               req_valid,
   output logic                    req_ready,
   input  wire pkors_pkg::req_type req_data,
   output logic                    rsp_valid,
   input  wire logic               rsp_ready,
   output pkors_pkg::rsp_type      rsp_data
);

   localparam int IW = $clog2(KEY_COUNT);
   localparam int CB = COUNT_BITS;
   localparam int W  = 16 + CB;          // sum_x, sum_t
   localparam int P  = 32 + CB;          // sum_xt, sum_xx
   localparam int AW = 34 + 2 * CB;      // numerator / denominator
   localparam int UW = AW + 32;          // shared unit width
   localparam int SW = $clog2(W + 34);   // step counter

   typedef enum logic [7:0] {
      S_CLEAR = 8'b0000_0001,
      S_IDLE  = 8'b0000_0010,
      S_LOOK  = 8'b0000_0100,
      S_MUL   = 8'b0000_1000,
      S_CHK   = 8'b0001_0000,
      S_NEG   = 8'b0010_0000,
      S_DIV   = 8'b0100_0000,
      S_FIN   = 8'b1000_0000
   } state_type;

   state_type state_ff, state_in;
   logic [IW-1:0] clr_ff, clr_in;
   pkors_pkg::req_type req_ff, req_in;
   logic key_ok_ff, key_ok_in;
   logic signed [31:0] pxt_ff, pxt_in, pxx_ff, pxx_in;
   logic [CB-1:0] cnt_ff, cnt_in;
   logic [W-1:0] sx_ff, sx_in, st_ff, st_in;
   logic [P-1:0] sxx_ff, sxx_in;
   logic [1:0] phase_ff, phase_in;
   logic [SW-1:0] step_ff, step_in;
   logic [UW-1:0] acc_ff, acc_in, opb_ff, opb_in;
   logic [W-1:0] mpl_ff, mpl_in;
   logic [AW-1:0] num_ff, num_in;
   logic neg_ff, neg_in;
   logic [32:0] q_ff, q_in;
   logic [31:0] slope_ff, slope_in;
   logic [1:0] status_ff, status_in;
   logic rsp_valid_ff, rsp_valid_in;
   pkors_pkg::rsp_type rsp_ff, rsp_in;

   // Table interface
   pkors_pkg::tbl_ctl_type tbl_ctl;
   logic [IW-1:0] wr_addr, rd_addr, acc_idx, ff_idx;
   logic [31:0] acc_key_ext, ff_key_ext;
   logic rd_seen;
   logic [CB-1:0] rd_cnt, base_cnt, wr_cnt;
   logic [W-1:0] rd_sx, rd_st, base_sx, base_st, wr_sx, wr_st;
   logic [P-1:0] rd_sxt, rd_sxx, base_sxt, base_sxx, wr_sxt, wr_sxx;

   // Shared unit
   logic [UW-1:0] alu_a, alu_b, alu_sum, acc_nxt;
   logic alu_sub, alu_carry;
   logic last_mul, last_div, cnt_full, sample_ok;
   logic [32:0] q_nxt;
   logic [AW-1:0] den;

   assign acc_key_ext = {22'd0, req_data.key};
   assign ff_key_ext  = {22'd0, req_ff.key};
   assign acc_idx     = acc_key_ext[IW-1:0];
   assign ff_idx      = ff_key_ext[IW-1:0];
   assign rd_addr     = (state_ff == S_IDLE) ? acc_idx : ff_idx;
   assign wr_addr     = (state_ff == S_CLEAR) ? clr_ff : ff_idx;

   pkors_table #(
      .KEY_COUNT (KEY_COUNT),
      .COUNT_BITS(COUNT_BITS)
   ) u_table (
      .clock  (clock),
      .ctl    (tbl_ctl),
      .wr_addr(wr_addr),
      .wr_cnt (wr_cnt),
      .wr_sx  (wr_sx),
      .wr_st  (wr_st),
      .wr_sxt (wr_sxt),
      .wr_sxx (wr_sxx),
      .rd_addr(rd_addr),
      .rd_seen(rd_seen),
      .rd_cnt (rd_cnt),
      .rd_sx  (rd_sx),
      .rd_st  (rd_st),
      .rd_sxt (rd_sxt),
      .rd_sxx (rd_sxx)
   );

   pkors_alu #(.WIDTH(UW)) u_alu (
      .a    (alu_a),
      .b    (alu_b),
      .sub  (alu_sub),
      .sum  (alu_sum),
      .carry(alu_carry)
   );

   // Sample update: unseen keys start from zero sums
   assign base_cnt  = rd_seen ? rd_cnt : '0;
   assign base_sx   = rd_seen ? rd_sx  : '0;
   assign base_st   = rd_seen ? rd_st  : '0;
   assign base_sxt  = rd_seen ? rd_sxt : '0;
   assign base_sxx  = rd_seen ? rd_sxx : '0;
   assign cnt_full  = &base_cnt;
   assign sample_ok = key_ok_ff && !req_ff.x_missing;
   assign wr_cnt    = base_cnt + {{(CB-1){1'b0}}, 1'b1};
   assign wr_sx     = base_sx + {{(W-16){req_ff.x_value[15]}}, req_ff.x_value};
   assign wr_st     = base_st + {{(W-16){req_ff.t_value[15]}}, req_ff.t_value};
   assign wr_sxt    = base_sxt + {{(P-32){pxt_ff[31]}}, pxt_ff};
   assign wr_sxx    = base_sxx + {{(P-32){pxx_ff[31]}}, pxx_ff};

   always_comb begin
      tbl_ctl = '0;
      if (state_ff == S_CLEAR) begin
         tbl_ctl.seen_we = 1'b1;
      end else if (state_ff == S_LOOK && req_ff.kind == pkors_pkg::KIND_SAMPLE
                   && sample_ok) begin
         tbl_ctl.seen_we   = 1'b1;
         tbl_ctl.seen_data = 1'b1;
         tbl_ctl.sums_we   = !cnt_full;
      end
   end

   assign last_mul = (step_ff == SW'(W - 1));
   assign last_div = (step_ff == SW'(32));
   assign den      = acc_ff[AW-1:0];

   // Shared unit operand select
   always_comb begin
      alu_a   = acc_ff;
      alu_b   = opb_ff;
      alu_sub = 1'b1;
      case (state_ff)
         S_MUL: alu_sub = phase_ff[0] ^ last_mul;
         S_NEG: begin
            alu_a = '0;
            alu_b = {{(UW-AW){num_ff[AW-1]}}, num_ff};
         end
         default: ;
      endcase
   end

   assign req_ready = (state_ff == S_IDLE);
   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_ff;

   // Sequencer and datapath next state
   always_comb begin
      state_in     = state_ff;
      clr_in       = clr_ff;
      req_in       = req_ff;
      key_ok_in    = key_ok_ff;
      pxt_in       = pxt_ff;
      pxx_in       = pxx_ff;
      cnt_in       = cnt_ff;
      sx_in        = sx_ff;
      st_in        = st_ff;
      sxx_in       = sxx_ff;
      phase_in     = phase_ff;
      step_in      = step_ff;
      acc_in       = acc_ff;
      opb_in       = opb_ff;
      mpl_in       = mpl_ff;
      num_in       = num_ff;
      neg_in       = neg_ff;
      q_in         = q_ff;
      slope_in     = slope_ff;
      status_in    = status_ff;
      rsp_in       = rsp_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_ready;
      acc_nxt      = mpl_ff[0] ? alu_sum : acc_ff;
      q_nxt        = {q_ff[31:0], alu_carry};

      case (state_ff)
         S_CLEAR: begin
            clr_in = clr_ff + {{(IW-1){1'b0}}, 1'b1};
            if (clr_ff == IW'(KEY_COUNT - 1)) begin
               state_in = S_IDLE;
            end
         end

         S_IDLE: begin
            if (req_valid) begin
               req_in    = req_data;
               key_ok_in = req_data.key_present && (acc_key_ext < 32'(KEY_COUNT));
               pxt_in    = 32'(req_data.x_value) * 32'(req_data.t_value);
               pxx_in    = 32'(req_data.x_value) * 32'(req_data.x_value);
               state_in  = S_LOOK;
            end
         end

         S_LOOK: begin
            if (req_ff.kind == pkors_pkg::KIND_SAMPLE) begin
               state_in = S_IDLE;
            end else if (!key_ok_ff || !rd_seen) begin
               slope_in  = '0;
               status_in = pkors_pkg::STAT_NO_SAMPLES;
               state_in  = S_FIN;
            end else begin
               cnt_in   = rd_cnt;
               sx_in    = rd_sx;
               st_in    = rd_st;
               sxx_in   = rd_sxx;
               acc_in   = '0;
               opb_in   = {{(UW-P){rd_sxt[P-1]}}, rd_sxt};
               mpl_in   = {{(W-CB){1'b0}}, rd_cnt};
               phase_in = 2'd0;
               step_in  = '0;
               state_in = S_MUL;
            end
         end

         // Shift-and-add: num = n*Sxt - Sx*St, den = n*Sxx - Sx*Sx
         S_MUL: begin
            acc_in  = acc_nxt;
            opb_in  = {opb_ff[UW-2:0], 1'b0};
            mpl_in  = {mpl_ff[W-1], mpl_ff[W-1:1]};
            step_in = step_ff + {{(SW-1){1'b0}}, 1'b1};
            if (last_mul) begin
               step_in  = '0;
               phase_in = phase_ff + 2'd1;
               case (phase_ff)
                  2'd0: begin
                     opb_in = {{(UW-W){st_ff[W-1]}}, st_ff};
                     mpl_in = sx_ff;
                  end
                  2'd1: begin
                     num_in = acc_nxt[AW-1:0];
                     acc_in = '0;
                     opb_in = {{(UW-P){sxx_ff[P-1]}}, sxx_ff};
                     mpl_in = {{(W-CB){1'b0}}, cnt_ff};
                  end
                  2'd2: begin
                     opb_in = {{(UW-W){sx_ff[W-1]}}, sx_ff};
                     mpl_in = sx_ff;
                  end
                  default: state_in = S_CHK;
               endcase
            end
         end

         S_CHK: begin
            if (den[AW-1] || den == '0) begin
               slope_in  = '0;
               status_in = pkors_pkg::STAT_ZERO_VAR;
               state_in  = S_FIN;
            end else begin
               neg_in  = num_ff[AW-1];
               opb_in  = {den, 32'd0};
               acc_in  = {16'd0, num_ff, 16'd0};
               step_in = '0;
               q_in    = '0;
               state_in = num_ff[AW-1] ? S_NEG : S_DIV;
            end
         end

         // Magnitude of a negative numerator, scaled by 2^16
         S_NEG: begin
            acc_in   = {16'd0, alu_sum[AW-1:0], 16'd0};
            state_in = S_DIV;
         end

         // Restoring division, quotient bits 32 down to 0
         S_DIV: begin
            if (alu_carry) begin
               acc_in = alu_sum;
            end
            q_in    = q_nxt;
            opb_in  = {1'b0, opb_ff[UW-1:1]};
            step_in = step_ff + {{(SW-1){1'b0}}, 1'b1};
            if (last_div) begin
               state_in  = S_FIN;
               status_in = pkors_pkg::STAT_OK;
               if (neg_ff) begin
                  if (q_nxt[32] || q_nxt[31:0] > 32'h8000_0000) begin
                     slope_in  = 32'h8000_0000;
                     status_in = pkors_pkg::STAT_SATURATED;
                  end else begin
                     slope_in = 32'd0 - q_nxt[31:0];
                  end
               end else begin
                  if (q_nxt[32] || q_nxt[31]) begin
                     slope_in  = 32'h7FFF_FFFF;
                     status_in = pkors_pkg::STAT_SATURATED;
                  end else begin
                     slope_in = q_nxt[31:0];
                  end
               end
            end
         end

         S_FIN: begin
            if (!rsp_valid_ff || rsp_ready) begin
               rsp_in.slope       = slope_ff;
               rsp_in.status      = status_ff;
               rsp_in.answer_slot = req_ff.result_slot;
               rsp_valid_in       = 1'b1;
               state_in           = S_IDLE;
            end
         end

         default: state_in = S_CLEAR;
      endcase
   end

   // Control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_CLEAR;
         clr_ff       <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         clr_ff       <= clr_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // Payload registers
   always_ff @(posedge clock) begin
      req_ff    <= req_in;
      key_ok_ff <= key_ok_in;
      pxt_ff    <= pxt_in;
      pxx_ff    <= pxx_in;
      cnt_ff    <= cnt_in;
      sx_ff     <= sx_in;
      st_ff     <= st_in;
      sxx_ff    <= sxx_in;
      phase_ff  <= phase_in;
      step_ff   <= step_in;
      acc_ff    <= acc_in;
      opb_ff    <= opb_in;
      mpl_ff    <= mpl_in;
      num_ff    <= num_in;
      neg_ff    <= neg_in;
      q_ff      <= q_in;
      slope_ff  <= slope_in;
      status_ff <= status_in;
      rsp_ff    <= rsp_in;
   end

   // One event in work at a time
   `PKORS_ASSERT_NEXT(a_one_in_work, req_valid && req_ready, !req_ready)
   // Unanswerable queries carry a zero slope
   `PKORS_ASSERT_IMPL(a_no_sample_zero, rsp_valid && rsp_data.status == pkors_pkg::STAT_NO_SAMPLES, rsp_data.slope == 32'sd0)
   // Saturated results sit at a range limit
   `PKORS_ASSERT_IMPL(a_sat_limit, rsp_valid && rsp_data.status == pkors_pkg::STAT_SATURATED, rsp_data.slope == 32'h7FFF_FFFF || rsp_data.slope == 32'h8000_0000)

endmodule

`default_nettype wire
